### rtl/core/vibration_rms_meter_core_macros.svh
// Assertion macros shared by the vibration RMS meter RTL.
// Each expects clk and rst_n in the scope where it is used.
`ifndef VIBRATION_RMS_METER_CORE_MACROS_SVH
`define VIBRATION_RMS_METER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VRM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define VRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/vrm_pkg.sv
// Package for the vibration RMS meter: field widths, defaults and state types.
// No dependencies; the interfaces, front end, back end and top refer to it by scoped names.
`default_nettype none

package vrm_pkg;

    // Field widths
    localparam int AXIS_W = 13;
    localparam int BASE_W = 13;
    localparam int RMS_W  = 17;
    localparam int MAG_W  = 17;
    // x^2 + y^2 + z^2 of 13-bit samples stays below 2^26
    localparam int SQ_W   = 2 * AXIS_W;
    // Square-sum accumulator
    localparam int SUM_W  = 48;
    // Fraction bits added to the square sum so the magnitude has 4 fraction bits
    localparam int SQ_FRAC = 8;

    localparam int SAMPLES_DEFAULT = 20;
    localparam int QUEUE_DEPTH     = 2;
    localparam logic [BASE_W-1:0] BASE_RESET = 13'd256;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MAG,
        B_DEV,
        B_SQR,
        B_ACC,
        B_DIV,
        B_ROOT,
        B_OUT
    } back_state_t;

endpackage

`default_nettype wire

### rtl/core/vrm_accel_if.sv
// Stream interface for one three-axis accelerometer sample per beat.
// Depends on vrm_pkg for the axis width.
`default_nettype none

interface vrm_accel_if;
    logic                                valid;
    logic                                ready;
    logic signed [vrm_pkg::AXIS_W-1:0]   accel_x;
    logic signed [vrm_pkg::AXIS_W-1:0]   accel_y;
    logic signed [vrm_pkg::AXIS_W-1:0]   accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    output ready);
endinterface

`default_nettype wire

### rtl/core/vrm_rms_if.sv
// Stream interface for one RMS result per beat.
// Depends on vrm_pkg for the result width.
`default_nettype none

interface vrm_rms_if;
    logic                        valid;
    logic                        ready;
    logic [vrm_pkg::RMS_W-1:0]   vibration_rms;

    modport source (output valid, output vibration_rms, input ready);
    modport sink   (input valid, input vibration_rms, output ready);
endinterface

`default_nettype wire

### rtl/core/vrm_front.sv
// Front end: accepts a sample beat and forms x^2 + y^2 + z^2 with one shared multiplier.
// Depends on vrm_pkg and vrm_accel_if; feeds the square sum to vrm_queue.
`default_nettype none

module vrm_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    vrm_accel_if.sink                        sample,
    output logic                             push_valid,
    input  wire logic                        push_ready,
    output logic [vrm_pkg::SQ_W-1:0]         push_data
);

    vrm_pkg::front_state_t state_reg, state_next;
    vrm_pkg::axis_t        axis_reg, axis_next;
    logic signed [vrm_pkg::AXIS_W-1:0] x_reg, y_reg, z_reg;
    logic [vrm_pkg::SQ_W-1:0]          acc_reg, acc_next;
    logic signed [vrm_pkg::AXIS_W-1:0] operand;
    logic [vrm_pkg::AXIS_W-1:0]        ax_abs;
    logic [vrm_pkg::SQ_W-1:0]          ax_sq;
    logic                              take;

    // Pick the axis for this cycle and square its magnitude
    always_comb
    begin
        unique case (axis_reg)
            vrm_pkg::AXIS_X: operand = x_reg;
            vrm_pkg::AXIS_Y: operand = y_reg;
            vrm_pkg::AXIS_Z: operand = z_reg;
            default:         operand = x_reg;
        endcase
    end

    assign ax_abs = operand[vrm_pkg::AXIS_W-1] ? (~operand + 1'b1) : operand;
    assign ax_sq  = ax_abs * ax_abs;

    assign take       = sample.valid && sample.ready;
    assign push_data  = acc_reg;

    // Next state and handshake outputs
    always_comb
    begin
        state_next   = state_reg;
        axis_next    = axis_reg;
        acc_next     = acc_reg;
        sample.ready = 1'b0;
        push_valid   = 1'b0;
        unique case (state_reg)
            vrm_pkg::F_IDLE:
            begin
                sample.ready = 1'b1;
                if (sample.valid)
                begin
                    axis_next  = vrm_pkg::AXIS_X;
                    acc_next   = '0;
                    state_next = vrm_pkg::F_MUL;
                end
            end
            vrm_pkg::F_MUL:
            begin
                acc_next = acc_reg + ax_sq;
                unique case (axis_reg)
                    vrm_pkg::AXIS_X: axis_next = vrm_pkg::AXIS_Y;
                    vrm_pkg::AXIS_Y: axis_next = vrm_pkg::AXIS_Z;
                    default:
                    begin
                        axis_next  = vrm_pkg::AXIS_X;
                        state_next = vrm_pkg::F_PUSH;
                    end
                endcase
            end
            vrm_pkg::F_PUSH:
            begin
                push_valid = 1'b1;
                if (push_ready)
                begin
                    state_next = vrm_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = vrm_pkg::F_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vrm_pkg::F_IDLE;
            axis_reg  <= vrm_pkg::AXIS_X;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    // Sample and square-sum datapath
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            x_reg <= sample.accel_x;
            y_reg <= sample.accel_y;
            z_reg <= sample.accel_z;
        end
        acc_reg <= acc_next;
    end

endmodule

`default_nettype wire

### rtl/core/vrm_queue.sv
// Short FIFO between the front end and the back end of the RMS meter.
// Depends on nothing but its parameters; register-based storage.
`default_nettype none

module vrm_queue #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push_valid,
    output logic                    push_ready,
    input  wire logic [WIDTH-1:0]   push_data,
    output logic                    pop_valid,
    input  wire logic               pop_ready,
    output logic [WIDTH-1:0]        pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_FULL);
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the pushed beat
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### rtl/core/vrm_back.sv
// Back end: magnitude square root, baseline deviation, squaring, block accumulation,
// mean by SAMPLES and the final square root. Depends on vrm_pkg, vrm_rms_if, macros.
`default_nettype none
`include "vibration_rms_meter_core_macros.svh"

module vrm_back #(
    parameter int SAMPLES = vrm_pkg::SAMPLES_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        q_valid,
    output logic                             q_ready,
    input  wire logic [vrm_pkg::SQ_W-1:0]    q_data,
    input  wire logic [vrm_pkg::BASE_W-1:0]  baseline,
    vrm_rms_if.source                        result
);

    localparam int SUM_W     = vrm_pkg::SUM_W;
    localparam int MAG_W     = vrm_pkg::MAG_W;
    localparam int RT_W      = SUM_W / 2;
    localparam int REM_W     = RT_W + 2;
    localparam int STEP_W    = $clog2(SUM_W);
    localparam int MAG_PAD   = SUM_W - vrm_pkg::SQ_W;
    localparam int MAG_STEPS = (vrm_pkg::SQ_W + vrm_pkg::SQ_FRAC) / 2;
    localparam int CNT_W     = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int DIV_W     = $clog2(SAMPLES + 1);
    // Divide one byte of the sum per cycle; the partial dividend is remainder:byte
    localparam int DIG_W     = 8;
    localparam int DIV_STEPS = SUM_W / DIG_W;
    localparam int P_W       = DIV_W + DIG_W;
    // Reciprocal rounded up; exact for any partial dividend below 2^P_W because
    // its rounding error times the dividend stays below 2^RCP_SH
    localparam int RCP_SH    = P_W + DIV_W;
    localparam int RCP_W     = RCP_SH + 1;
    localparam logic [RCP_W-1:0]  RCP       =
        RCP_W'(((64'd1 << RCP_SH) + 64'(SAMPLES - 1)) / 64'(SAMPLES));
    localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(SAMPLES - 1);
    localparam logic [DIV_W-1:0]  DIVISOR   = DIV_W'(SAMPLES);
    localparam logic [STEP_W-1:0] MAG_FIRST = STEP_W'(MAG_STEPS - 1);
    localparam logic [STEP_W-1:0] DIV_FIRST = STEP_W'(DIV_STEPS - 1);
    localparam logic [STEP_W-1:0] RT_FIRST  = STEP_W'(RT_W - 1);

    vrm_pkg::back_state_t state_reg, state_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [SUM_W-1:0]     op_reg, op_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [RT_W-1:0]      root_reg, root_next;
    logic [DIV_W-1:0]     drem_reg, drem_next;
    logic [MAG_W-1:0]     adev_reg, adev_next;
    logic [2*MAG_W-1:0]   prod_reg;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 rms_valid_reg, rms_valid_next;
    logic [vrm_pkg::RMS_W-1:0] rms_data_reg, rms_data_next;

    // Square-root step: one root bit per cycle from the top two operand bits
    logic [REM_W+1:0] sq_r4, sq_trial, sq_diff;
    logic             sq_ge;
    // Division step: one quotient byte per cycle by reciprocal multiplication
    logic [P_W-1:0]       dv_p, dv_r;
    logic [P_W+RCP_W-1:0] dv_prod;
    logic [DIG_W-1:0]     dv_q;
    // Deviation from the baseline, both in counts with 4 fraction bits
    logic signed [MAG_W:0] dev;
    logic [MAG_W:0]        dev_abs;
    logic [SUM_W-1:0]      sum_add;

    assign sq_r4    = {rem_reg, op_reg[SUM_W-1 -: 2]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_ge    = (sq_r4 >= sq_trial);
    assign sq_diff  = sq_r4 - sq_trial;

    assign dv_p     = {drem_reg, op_reg[SUM_W-1 -: DIG_W]};
    assign dv_prod  = dv_p * RCP;
    assign dv_q     = dv_prod[RCP_SH +: DIG_W];
    assign dv_r     = dv_p - (P_W'(dv_q) * P_W'(DIVISOR));

    assign dev      = $signed({1'b0, root_reg[MAG_W-1:0]}) - $signed({1'b0, baseline, 4'b0000});
    assign dev_abs  = dev[MAG_W] ? (~dev + 1'b1) : dev;
    assign sum_add  = sum_reg + SUM_W'(prod_reg);

    assign result.valid         = rms_valid_reg;
    assign result.vibration_rms = rms_data_reg;

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        op_next        = op_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        drem_next      = drem_reg;
        adev_next      = adev_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        rms_valid_next = rms_valid_reg;
        rms_data_next  = rms_data_reg;
        q_ready        = 1'b0;

        // Drop the result once it is taken
        if (rms_valid_reg && result.ready)
        begin
            rms_valid_next = 1'b0;
        end

        unique case (state_reg)
            vrm_pkg::B_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    // Square sum times 256, left-aligned for the root steps
                    op_next    = {q_data, MAG_PAD'(0)};
                    rem_next   = '0;
                    root_next  = '0;
                    step_next  = MAG_FIRST;
                    state_next = vrm_pkg::B_MAG;
                end
            end
            vrm_pkg::B_MAG, vrm_pkg::B_ROOT:
            begin
                op_next   = {op_reg[SUM_W-3:0], 2'b00};
                rem_next  = sq_ge ? sq_diff[REM_W-1:0] : sq_r4[REM_W-1:0];
                root_next = {root_reg[RT_W-2:0], sq_ge};
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    state_next = (state_reg == vrm_pkg::B_MAG) ? vrm_pkg::B_DEV
                                                               : vrm_pkg::B_OUT;
                end
            end
            vrm_pkg::B_DEV:
            begin
                adev_next  = dev_abs[MAG_W-1:0];
                state_next = vrm_pkg::B_SQR;
            end
            vrm_pkg::B_SQR:
            begin
                state_next = vrm_pkg::B_ACC;
            end
            vrm_pkg::B_ACC:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    // Block complete: divide the sum, then restart the block
                    op_next    = sum_add;
                    drem_next  = '0;
                    sum_next   = '0;
                    cnt_next   = '0;
                    step_next  = DIV_FIRST;
                    state_next = vrm_pkg::B_DIV;
                end
                else
                begin
                    sum_next   = sum_add;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = vrm_pkg::B_IDLE;
                end
            end
            vrm_pkg::B_DIV:
            begin
                op_next   = {op_reg[SUM_W-DIG_W-1:0], dv_q};
                drem_next = dv_r[DIV_W-1:0];
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    rem_next   = '0;
                    root_next  = '0;
                    step_next  = RT_FIRST;
                    state_next = vrm_pkg::B_ROOT;
                end
            end
            vrm_pkg::B_OUT:
            begin
                // Hold until the output register is free
                if (!rms_valid_reg || result.ready)
                begin
                    rms_valid_next = 1'b1;
                    rms_data_next  = root_reg[vrm_pkg::RMS_W-1:0];
                    state_next     = vrm_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = vrm_pkg::B_IDLE;
            end
        endcase
    end

    // Control state, block accumulator and sample count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vrm_pkg::B_IDLE;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            rms_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            rms_valid_reg <= rms_valid_next;
        end
    end

    // Arithmetic datapath
    always_ff @(posedge clk)
    begin
        step_reg     <= step_next;
        op_reg       <= op_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        drem_reg     <= drem_next;
        adev_reg     <= adev_next;
        prod_reg     <= adev_reg * adev_reg;
        rms_data_reg <= rms_data_next;
    end

    `VRM_ASSERT_NOW(a_cnt_range, 1'b1, cnt_reg <= CNT_LAST, "sample count beyond block")
    `VRM_ASSERT_NEXT(a_mag_start, state_reg == vrm_pkg::B_IDLE && q_valid, state_reg == vrm_pkg::B_MAG && root_reg == '0, "magnitude root did not start")
    `VRM_ASSERT_NEXT(a_block_clear, state_reg == vrm_pkg::B_ACC && cnt_reg == CNT_LAST, sum_reg == '0 && cnt_reg == '0 && state_reg == vrm_pkg::B_DIV, "block end did not clear")
    `VRM_ASSERT_NOW(a_out_load, $rose(rms_valid_reg), $past(state_reg) == vrm_pkg::B_OUT, "result loaded outside output step")

endmodule

`default_nettype wire

### rtl/core/vibration_rms_meter_core.sv
// From the last sample of a block to its RMS beat the path runs through the square sum and
// the queue, the magnitude pass, the divide and the root.
// Sustained throughput is set by the back end's one-bit-per-cycle magnitude root;
// the front end feeds square sums into a 2-entry queue and waits while it is full.
// Each block end adds the divide and root passes. Reset clears the accumulator, the count and the queue
// and sets the baseline to 256; no clearing pass.
`default_nettype none

module vibration_rms_meter_core #(
    parameter int SAMPLES = vrm_pkg::SAMPLES_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    vrm_accel_if.sink                        sample,
    vrm_rms_if.source                        result,
    input  wire logic                        cfg_we,
    input  wire logic [vrm_pkg::BASE_W-1:0]  cfg_wdata
);

    logic [vrm_pkg::BASE_W-1:0] baseline_reg;
    logic                       push_valid, push_ready;
    logic [vrm_pkg::SQ_W-1:0]   push_data;
    logic                       q_valid, q_ready;
    logic [vrm_pkg::SQ_W-1:0]   q_data;

    // Baseline magnitude register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg <= vrm_pkg::BASE_RESET;
        end
        else if (cfg_we)
        begin
            baseline_reg <= cfg_wdata;
        end
    end

    vrm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    vrm_queue #(
        .WIDTH (vrm_pkg::SQ_W),
        .DEPTH (vrm_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    vrm_back #(
        .SAMPLES (SAMPLES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data),
        .baseline (baseline_reg),
        .result   (result)
    );

endmodule

`default_nettype wire
